// ----- src/ultrasonic_echo_ranger_defines.svh -----
// assertion macros for the ultrasonic echo ranger
// used by the top level; expects signals clk and rst_n in scope
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// same-cycle implication, inactive while in reset
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive while in reset
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/uer_pkg.sv -----
// shared types and constants for the ultrasonic echo ranger
// no dependencies
`timescale 1ns / 1ps

package uer_pkg;

    // field and counter widths
    localparam int TRIG_W   = 16;
    localparam int TMO_W    = 32;
    localparam int SCALE_W  = 24;
    localparam int CNT_W    = 32;
    localparam int DIST_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = CNT_W + SCALE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd2;

    // register reset values
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = 16'd10;
    localparam logic [TMO_W-1:0]   TIMEOUT_TICKS_RST  = 32'd1000000;
    localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 24'd11246;

    // measurement status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_RISE = 2'd1;
    localparam logic [1:0] STATUS_NO_FALL = 2'd2;

    // measurement phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_TRIG      = 4'b0010,
        PH_WAIT_HIGH = 4'b0100,
        PH_WAIT_LOW  = 4'b1000
    } phase_t;

    // one tick in
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } uer_in_t;

    // one result out
    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        status;
        logic [CNT_W-1:0]  echo_ticks;
        logic [DIST_W-1:0] distance_mm;
    } uer_out_t;

    // per-tick outcome of the sequencer, distance still to be worked out
    typedef struct packed {
        logic             trigger_level;
        logic             busy_res;
        logic             done_res;
        logic [1:0]       status;
        logic [CNT_W-1:0] echo_ticks;
        logic             dist_ok;
    } uer_step_t;

endpackage

// ----- src/uer_seq.sv -----
// measurement sequencer: phase, elapsed and pulse width counters
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  uer_pkg::uer_in_t            tick,
    input  logic [uer_pkg::TRIG_W-1:0]  trigger_ticks,
    input  logic [uer_pkg::TMO_W-1:0]   timeout_ticks,
    output uer_pkg::uer_step_t          step
);

    uer_pkg::phase_t                 phase_reg, phase_next, ph_eff;
    logic [uer_pkg::CNT_W-1:0]       elapsed_reg, elapsed_next;
    logic [uer_pkg::CNT_W-1:0]       pulse_reg, pulse_next;
    logic [uer_pkg::CNT_W-1:0]       el_base, el_inc, pw_inc;
    logic                            start_now;

    // effective phase, a start in idle enters the trigger phase on the same tick
    always_comb
    begin
        start_now = 1'b0;
        case (phase_reg)
            uer_pkg::PH_TRIG,
            uer_pkg::PH_WAIT_HIGH,
            uer_pkg::PH_WAIT_LOW: ph_eff = phase_reg;
            default:
            begin
                start_now = tick.start_req;
                ph_eff    = tick.start_req ? uer_pkg::PH_TRIG : uer_pkg::PH_IDLE;
            end
        endcase
    end

    // saturating increments
    assign el_base = start_now ? '0 : elapsed_reg;
    assign el_inc  = (el_base == '1) ? el_base : el_base + 1'b1;
    assign pw_inc  = (pulse_reg == '1) ? pulse_reg : pulse_reg + 1'b1;

    // next state and per-tick outcome
    always_comb
    begin
        phase_next         = ph_eff;
        elapsed_next       = el_base;
        pulse_next         = start_now ? '0 : pulse_reg;
        step               = '0;
        case (ph_eff)
            uer_pkg::PH_TRIG:
            begin
                step.trigger_level = 1'b1;
                if (el_inc >= uer_pkg::CNT_W'(trigger_ticks))
                begin
                    phase_next   = uer_pkg::PH_WAIT_HIGH;
                    elapsed_next = '0;
                end
                else
                begin
                    elapsed_next = el_inc;
                end
            end
            uer_pkg::PH_WAIT_HIGH:
            begin
                if (tick.echo_level)
                begin
                    phase_next   = uer_pkg::PH_WAIT_LOW;
                    elapsed_next = '0;
                    pulse_next   = uer_pkg::CNT_W'(1);
                end
                else
                begin
                    elapsed_next = el_inc;
                    if (el_inc > uer_pkg::CNT_W'(timeout_ticks))
                    begin
                        step.done_res = 1'b1;
                        step.status   = uer_pkg::STATUS_NO_RISE;
                        phase_next    = uer_pkg::PH_IDLE;
                    end
                end
            end
            uer_pkg::PH_WAIT_LOW:
            begin
                if (tick.echo_level)
                begin
                    pulse_next   = pw_inc;
                    elapsed_next = el_inc;
                    if (el_inc > uer_pkg::CNT_W'(timeout_ticks))
                    begin
                        step.done_res   = 1'b1;
                        step.status     = uer_pkg::STATUS_NO_FALL;
                        step.echo_ticks = pw_inc;
                        phase_next      = uer_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    step.done_res   = 1'b1;
                    step.status     = uer_pkg::STATUS_OK;
                    step.echo_ticks = pulse_reg;
                    step.dist_ok    = 1'b1;
                    phase_next      = uer_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
        step.busy_res = (phase_next != uer_pkg::PH_IDLE);
    end

    // state registers advance once per tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= uer_pkg::PH_IDLE;
            elapsed_reg <= '0;
            pulse_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            pulse_reg   <= pulse_next;
        end
    end

endmodule

// ----- src/uer_dist.sv -----
// width to distance: registered multiply, then rounding and saturation
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_dist (
    input  logic                         clk,
    input  logic                         mul_en,
    input  logic                         sat_en,
    input  logic                         dist_ok,
    input  logic [uer_pkg::CNT_W-1:0]    width,
    input  logic [uer_pkg::SCALE_W-1:0]  scale,
    output logic [uer_pkg::DIST_W-1:0]   distance
);

    localparam int RND_W = uer_pkg::PROD_W + 1;
    localparam int Q_W   = RND_W - uer_pkg::FRAC_W;

    logic [uer_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [RND_W-1:0]           rnd;
    logic [Q_W-1:0]             quot;
    logic [uer_pkg::DIST_W-1:0] dist_reg, dist_next;

    // product of width and Q16 scale, zero when no distance is due
    assign prod_next = dist_ok
        ? (uer_pkg::PROD_W'(width) * uer_pkg::PROD_W'(scale)) : '0;

    // round half up, drop the fraction, clip at the field maximum
    assign rnd  = RND_W'(prod_reg) + RND_W'(1 << (uer_pkg::FRAC_W - 1));
    assign quot = rnd[RND_W-1:uer_pkg::FRAC_W];
    assign dist_next = (|quot[Q_W-1:uer_pkg::DIST_W]) ? '1 : quot[uer_pkg::DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (sat_en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

endmodule

// ----- src/ultrasonic_echo_ranger.sv -----
// ultrasonic echo ranger: one timer tick in, one result out
// throughput: one tick per cycle while result_stall is low; input register, sequencer
//   step, multiplier and rounding stage all run concurrently
// reset: asynchronous, registers to defaults, phase idle, counters zero,
//   pipeline empty
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_stall,
    input  uer_pkg::uer_in_t                 tick,
    output logic                             result_valid,
    input  logic                             result_stall,
    output uer_pkg::uer_out_t                result,
    input  logic                             cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [uer_pkg::TRIG_W-1:0]  trigger_ticks_reg;
    logic [uer_pkg::TMO_W-1:0]   timeout_ticks_reg;
    logic [uer_pkg::SCALE_W-1:0] distance_scale_reg;

    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic               rdy0, rdy1, rdy2, rdy3;
    uer_pkg::uer_in_t   in_reg;
    uer_pkg::uer_step_t step_next, step1_reg, step2_reg, step3_reg;
    logic [uer_pkg::DIST_W-1:0] distance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg  <= uer_pkg::TRIGGER_TICKS_RST;
            timeout_ticks_reg  <= uer_pkg::TIMEOUT_TICKS_RST;
            distance_scale_reg <= uer_pkg::DISTANCE_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::CFG_TRIGGER_TICKS:  trigger_ticks_reg  <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data[uer_pkg::TMO_W-1:0];
                uer_pkg::CFG_DISTANCE_SCALE: distance_scale_reg <= cfg_data[uer_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ready chain, each stage moves when it is empty or the next one moves
    assign rdy3 = !v3_reg || !result_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign tick_stall = !rdy0;

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= tick_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (tick_valid && rdy0) in_reg    <= tick;
        if (v0_reg && rdy1)     step1_reg <= step_next;
        if (v1_reg && rdy2)     step2_reg <= step1_reg;
        if (v2_reg && rdy3)     step3_reg <= step2_reg;
    end

    // measurement sequencer, steps once per tick leaving the input register
    uer_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (v0_reg && rdy1),
        .tick          (in_reg),
        .trigger_ticks (trigger_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .step          (step_next)
    );

    // distance arithmetic runs alongside stages two and three
    uer_dist u_dist (
        .clk      (clk),
        .mul_en   (v1_reg && rdy2),
        .sat_en   (v2_reg && rdy3),
        .dist_ok  (step1_reg.dist_ok),
        .width    (step1_reg.echo_ticks),
        .scale    (distance_scale_reg),
        .distance (distance)
    );

    // result transfer
    assign result_valid          = v3_reg;
    assign result.trigger_level  = step3_reg.trigger_level;
    assign result.busy_res       = step3_reg.busy_res;
    assign result.done_res       = step3_reg.done_res;
    assign result.status         = step3_reg.status;
    assign result.echo_ticks     = step3_reg.echo_ticks;
    assign result.distance_mm    = distance;

    // checks on the result stream and the pipeline
    `UER_ASSERT_NOW(a_idle_fields_zero, result_valid && !result.done_res,
        (result.status == uer_pkg::STATUS_OK) && (result.echo_ticks == '0)
        && (result.distance_mm == '0), "result fields set without a finished measurement")
    `UER_ASSERT_NOW(a_done_not_busy, result_valid && result.done_res, !result.busy_res,
        "finished measurement still reported busy")
    `UER_ASSERT_NOW(a_trig_busy, result_valid && result.trigger_level && !result.done_res,
        result.busy_res, "trigger driven outside a measurement")
    `UER_ASSERT_NOW(a_no_dist_on_timeout, result_valid && result.done_res
        && (result.status != uer_pkg::STATUS_OK), result.distance_mm == '0,
        "distance reported on a timeout")
    `UER_ASSERT_NEXT(a_stall_needs_full, tick_stall, v0_reg && v1_reg,
        "input stalled with an empty front end")

endmodule
